>>> rtl/core/sequence_window_frame_assembler_core_defines.svh
// assertion helpers shared by the frame assembler rtl
`ifndef SEQUENCE_WINDOW_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define SEQUENCE_WINDOW_FRAME_ASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SWFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define SWFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/swfa_pkg.sv
package swfa_pkg;

  // result kinds, also used as the record class inside the block
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_SEQ_OOW = 2'd1;
  localparam logic [1:0] KIND_BAD_ID = 2'd2;
  localparam logic [1:0] KIND_ENTRY = 2'd3;

  // most entries one publish may emit
  localparam int RESULT_LIMIT = 32;

  localparam logic [5:0] SENSOR_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] meas;
    logic [31:0] refv;
    logic [31:0] stat;
  } rec_t;

  typedef struct packed {
    logic in_load;     // capture the input word
    logic store_wr;    // write the record to its frame
    logic emit_short;  // load a single-word result into the output register
    logic idx_clr;     // start a publish walk
    logic pub_rd;      // read the current frame at the walk index
    logic pub_emit;    // load the read entry into the output register
    logic idx_inc;     // advance the walk index
    logic pub_commit;  // swap frames, bump sequence numbers, store the record
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;  // class of the captured record
    logic out_free;    // output register can take a word this cycle
    logic pub_last;    // walk index is on the last entry
  } status_t;

endpackage

>>> rtl/core/swfa_ram.sv
module swfa_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/swfa_ctrl.sv
module swfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swfa_pkg::status_t status,
  output swfa_pkg::cmd_t    cmd
);

  import swfa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_PUB_RD = 3'd2;
  localparam logic [2:0] ST_PUB_OUT = 3'd3;
  localparam logic [2:0] ST_PUB_END = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.kind == KIND_ENTRY) begin
          cmd.idx_clr = 1'b1;
          state_next = ST_PUB_RD;
        end else if (status.out_free) begin
          cmd.emit_short = 1'b1;
          cmd.store_wr = (status.kind == KIND_ACCEPT);
          state_next = ST_IDLE;
        end
      end
      ST_PUB_RD: begin
        cmd.pub_rd = 1'b1;
        state_next = ST_PUB_OUT;
      end
      ST_PUB_OUT: begin
        if (status.out_free) begin
          cmd.pub_emit = 1'b1;
          if (status.pub_last) begin
            state_next = ST_PUB_END;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = ST_PUB_RD;
          end
        end
      end
      ST_PUB_END: begin
        cmd.pub_commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/swfa_dp.sv
module swfa_dp #(
  parameter int MAX_SENSORS = 32,
  localparam int DEPTH = 2 * MAX_SENSORS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  input  logic [135:0]      in_data,
  input  swfa_pkg::cmd_t    cmd,
  output swfa_pkg::status_t status,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output swfa_pkg::rec_t    ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  swfa_pkg::rec_t    ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [4:0]        out_dev,
  output swfa_pkg::rec_t    out_rec,
  output logic              out_last
);

  import swfa_pkg::*;

  localparam logic [5:0] CAP = 6'((MAX_SENSORS < RESULT_LIMIT) ? MAX_SENSORS : RESULT_LIMIT);
  localparam logic [AW-1:0] BANK1_BASE = AW'(MAX_SENSORS);
  localparam logic [DEPTH-1:0] LO_HALF = {{MAX_SENSORS{1'b0}}, {MAX_SENSORS{1'b1}}};

  logic [5:0]       sensor_count;
  logic [7:0]       in_dev;
  rec_t             in_rec;
  logic [31:0]      seq_cur;
  logic [31:0]      seq_nxt;
  logic             bank;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] valid_next;
  logic [4:0]       idx;
  logic             rd_valid;

  logic [5:0]    cnt_eff;
  logic          is_bad;
  logic          is_zero;
  logic          match_cur;
  logic          match_nxt;
  logic          match_pub;
  logic          store_bank;
  logic          wr_bank;
  logic [1:0]    kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count <= SENSOR_COUNT_RESET;
    end else if (cfg_we) begin
      sensor_count <= cfg_wdata;
    end
  end

  assign cnt_eff = (sensor_count > CAP) ? CAP : sensor_count;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_dev <= in_data[7:0];
      in_rec.seq <= in_data[39:8];
      in_rec.meas <= in_data[71:40];
      in_rec.refv <= in_data[103:72];
      in_rec.stat <= in_data[135:104];
    end
  end

  // record classification, a bad device id wins over all, then sequence 0 wins over current, then next, then next+1
  assign is_bad = ({2'b00, cnt_eff} <= in_dev);
  assign is_zero = (in_rec.seq == 32'd0);
  assign match_cur = (in_rec.seq == seq_cur);
  assign match_nxt = (in_rec.seq == seq_nxt);
  assign match_pub = (in_rec.seq == seq_nxt + 32'd1);

  always_comb begin
    priority if (is_bad) begin
      kind = KIND_BAD_ID;
    end else if (is_zero || match_cur || match_nxt) begin
      kind = KIND_ACCEPT;
    end else if (match_pub) begin
      kind = KIND_ENTRY;
    end else begin
      kind = KIND_SEQ_OOW;
    end
  end

  assign store_bank = (is_zero || match_cur) ? bank : ~bank;
  // after a publish the record lands in the old current half, the new next frame
  assign wr_bank = cmd.pub_commit ? bank : store_bank;

  assign ram_we = cmd.store_wr | cmd.pub_commit;
  assign ram_waddr = (wr_bank ? BANK1_BASE : '0) + AW'(in_dev[4:0]);
  assign ram_wdata = in_rec;
  assign ram_re = cmd.pub_rd;
  assign ram_raddr = (bank ? BANK1_BASE : '0) + AW'(idx);

  always_comb begin
    valid_next = valid;
    if (cmd.pub_commit) begin
      valid_next = valid & (bank ? LO_HALF : ~LO_HALF);
    end
    if (ram_we) begin
      valid_next[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      bank <= 1'b0;
      seq_cur <= '0;
      seq_nxt <= '0;
    end else begin
      valid <= valid_next;
      if (cmd.store_wr && is_zero) begin
        seq_cur <= 32'd0;
        seq_nxt <= 32'd1;
      end
      if (cmd.pub_commit) begin
        bank <= ~bank;
        seq_cur <= seq_cur + 32'd1;
        seq_nxt <= seq_nxt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 5'd1;
    end
    if (cmd.pub_rd) begin
      rd_valid <= valid[ram_raddr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_short || cmd.pub_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_short) begin
      out_kind <= kind;
      out_dev <= '0;
      out_rec <= '0;
      out_last <= 1'b1;
    end else if (cmd.pub_emit) begin
      out_kind <= KIND_ENTRY;
      out_dev <= idx;
      out_rec <= rd_valid ? ram_rdata : '0;
      out_last <= status.pub_last;
    end
  end

  assign status.kind = kind;
  assign status.out_free = ~out_valid | out_ready;
  assign status.pub_last = (({1'b0, idx} + 6'd1) == cnt_eff);

endmodule

>>> rtl/core/sequence_window_frame_assembler_core.sv
// Sequence window frame assembler. Each input word is one sensor record; the block
// keeps a current and a next frame (one entry per sensor, in one 2*MAX_SENSORS deep
// frame RAM split in two halves) and their sequence numbers. Sequence 0 restarts the
// window, a match with current or next stores the record there, next+1 publishes the
// current frame entry by entry (kind 3, unwritten entries as zeros, tlast on the last)
// and then swaps frames and stores the record; anything else gives a kind 1 word and
// a device id at or above the sensor count a kind 2 word. An ordinary record is captured,
// then classified and written. A publish walks the frame, each entry a RAM read followed
// by a load of the output register, then swaps frames. Backpressure on the output stalls
// the classify and load steps; the output register lets the next record be taken while a
// word still waits. Entry valid bits are flip-flops, so there is no clearing pass.
`include "sequence_window_frame_assembler_core_defines.svh"

module sequence_window_frame_assembler_core #(
  parameter int MAX_SENSORS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // sensor count register
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata,
  // input records
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // device_id[7:0], sequence_nr[39:8], value_measured[71:40],
  // value_reference[103:72], sensor_status[135:104]
  input  logic [135:0] s_axis_tdata,
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_device_id[4:0], out_sequence_nr[36:5], out_value_measured[68:37],
  // out_value_reference[100:69], out_status[132:101], zero pad[135:133]
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser
);

  import swfa_pkg::*;

  localparam int DEPTH = 2 * MAX_SENSORS;
  localparam int AW = $clog2(DEPTH);

  cmd_t    cmd;
  status_t status;

  // frame ram side
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_rdata;

  // output register contents
  logic [4:0] out_dev;
  rec_t       out_rec;

  // controller: one record at a time, walks the publish one entry at a time, a RAM read then an output load
  swfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: window state, valid bits, walk index and output register
  swfa_dp #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_dev   (out_dev),
    .out_rec   (out_rec),
    .out_last  (m_axis_tlast)
  );

  // both frames live here, the current bank bit picks the half
  swfa_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata = {3'b000, out_rec.stat, out_rec.refv, out_rec.meas, out_rec.seq, out_dev};

  // a record is taken only from idle, so the cycle after a take is never ready
  `SWFA_ASSERT_NEXT(a_one_record, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "record taken while busy")
  // results are only loaded into a free output register
  `SWFA_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.emit_short || cmd.pub_emit, !m_axis_tvalid || m_axis_tready, "result word overwritten")
  // single-word results always close their run
  `SWFA_ASSERT_NOW(a_short_last, clk, rst, m_axis_tvalid && (m_axis_tuser != KIND_ENTRY), m_axis_tlast, "short result without tlast")
  // the frame ram never reads and writes in one cycle
  `SWFA_ASSERT_NOW(a_ram_excl, clk, rst, ram_we, !ram_re, "frame ram read during write")

endmodule

>>> sim/sequence_window_frame_assembler_core_tb.sv
`timescale 1ns / 100ps

module sequence_window_frame_assembler_core_tb;
  import swfa_pkg::*;

  localparam int MAX_SENSORS = 32;
  localparam int HOLD_CYCLES = 400;  // long output back-pressure stretch

  // one input sensor record as carried on the slave side
  typedef struct packed {
    logic [7:0] dev;
    rec_t       body;
  } sensor_in_t;

  // one result word as carried on the master side
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] dev;
    rec_t       body;
    logic       last;
  } frame_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [5:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // device_id, sequence_nr, value_measured, value_reference, sensor_status
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_device_id, out_sequence_nr, out_value_measured, out_value_reference,
  // out_status, zero pad
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;
  // kind
  logic [1:0]   m_axis_tuser;

  sequence_window_frame_assembler_core #(
    .MAX_SENSORS(MAX_SENSORS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  // records waiting for the driver, result words waiting for the block
  sensor_in_t  records_to_send[$];
  frame_word_t expected_words[$];

  // frame predictor state
  rec_t        frame_mem [0:2*MAX_SENSORS-1];
  bit          frame_hit [0:2*MAX_SENSORS-1];
  bit          live_bank;
  logic [31:0] win_cur, win_nxt;
  logic [5:0]  count_cfg;

  // stimulus side view of the window, advanced as records are queued
  logic [31:0] gen_cur, gen_nxt;
  int          gen_count;

  bit in_fire = 1'b0;  // slave handshake at the last rising edge
  bit steady = 1'b0;   // no random idling on either side
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int mismatches = 0;
  int records_taken = 0;
  int counts_used = 0;
  int kinds_seen [4];

  task automatic file_entry(input bit bank, input sensor_in_t r);
    int idx;
    idx = (bank ? MAX_SENSORS : 0) + r.dev[4:0];
    frame_mem[idx] = r.body;
    frame_hit[idx] = 1'b1;
  endtask

  // expected words for one accepted record, frame state updated along the way
  task automatic assemble_record(input sensor_in_t r);
    int n, base, i;
    bit publishing;
    frame_word_t w;
    n = count_cfg;
    if (n > MAX_SENSORS) n = MAX_SENSORS;
    if (n > RESULT_LIMIT) n = RESULT_LIMIT;
    publishing = 1'b0;
    w = '0;
    w.last = 1'b1;
    if (r.dev >= n) begin
      // out of range id, sequence never looked at
      w.kind = KIND_BAD_ID;
    end else if (r.body.seq == 32'd0) begin
      win_cur = 32'd0;
      win_nxt = 32'd1;
      file_entry(live_bank, r);
      w.kind = KIND_ACCEPT;
    end else if (r.body.seq == win_cur) begin
      file_entry(live_bank, r);
      w.kind = KIND_ACCEPT;
    end else if (r.body.seq == win_nxt) begin
      file_entry(~live_bank, r);
      w.kind = KIND_ACCEPT;
    end else if (r.body.seq == win_nxt + 32'd1) begin
      // walk the current frame, unwritten entries read as zeros
      publishing = 1'b1;
      base = live_bank ? MAX_SENSORS : 0;
      for (i = 0; i < n; i++) begin
        w.kind = KIND_ENTRY;
        w.dev = i[4:0];
        w.body = frame_hit[base+i] ? frame_mem[base+i] : '0;
        w.last = (i == n - 1);
        expected_words.push_back(w);
      end
      for (i = 0; i < MAX_SENSORS; i++) frame_hit[base+i] = 1'b0;
      live_bank = ~live_bank;
      win_cur = win_cur + 32'd1;
      win_nxt = win_nxt + 32'd1;
      file_entry(~live_bank, r);
    end else begin
      w.kind = KIND_SEQ_OOW;
    end
    if (!publishing) expected_words.push_back(w);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // input handshake, predictor and result compare, all on the rising edge
  always @(posedge clk) begin : frame_scoreboard
    frame_word_t got, want;
    sensor_in_t rec;
    int i;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst) begin
      for (i = 0; i < 2 * MAX_SENSORS; i++) frame_hit[i] = 1'b0;
      live_bank = 1'b0;
      win_cur = 32'd0;
      win_nxt = 32'd0;
      count_cfg = SENSOR_COUNT_RESET;
    end else begin
      if (cfg_we) count_cfg = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.dev = m_axis_tdata[4:0];
        got.body.seq = m_axis_tdata[36:5];
        got.body.meas = m_axis_tdata[68:37];
        got.body.refv = m_axis_tdata[100:69];
        got.body.stat = m_axis_tdata[132:101];
        got.last = m_axis_tlast;
        kinds_seen[got.kind]++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, kind %0d dev %0d last %0b", $time,
                   got.kind, got.dev, got.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("out_device_id", want.dev, got.dev);
          compare_field("out_sequence_nr", want.body.seq, got.body.seq);
          compare_field("out_value_measured", want.body.meas, got.body.meas);
          compare_field("out_value_reference", want.body.refv, got.body.refv);
          compare_field("out_status", want.body.stat, got.body.stat);
          compare_field("last", want.last, got.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rec.dev = s_axis_tdata[7:0];
        rec.body.seq = s_axis_tdata[39:8];
        rec.body.meas = s_axis_tdata[71:40];
        rec.body.refv = s_axis_tdata[103:72];
        rec.body.stat = s_axis_tdata[135:104];
        assemble_record(rec);
        records_taken++;
      end
    end
  end

  // record driver, holds a word until it is taken
  always @(negedge clk) begin : record_driver
    sensor_in_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (records_to_send.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        nxt = records_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nxt.body.stat, nxt.body.refv, nxt.body.meas, nxt.body.seq,
                         nxt.dev};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink, random stalls plus an occasional long hold-off
  always @(negedge clk) begin : result_sink
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || $urandom_range(99) >= 11;
    end
  end

  task automatic set_sensor_count(input logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_count = (v > MAX_SENSORS) ? MAX_SENSORS : v;
    counts_used++;
  endtask

  // queue a record and track where the window will be once it is taken
  task automatic queue_record(input logic [7:0] dev, input logic [31:0] seq,
                              input logic [31:0] meas, input logic [31:0] refv,
                              input logic [31:0] stat);
    sensor_in_t r;
    r.dev = dev;
    r.body.seq = seq;
    r.body.meas = meas;
    r.body.refv = refv;
    r.body.stat = stat;
    records_to_send.push_back(r);
    if (dev < gen_count) begin
      if (seq == 32'd0) begin
        gen_cur = 32'd0;
        gen_nxt = 32'd1;
      end else if (seq != gen_cur && seq != gen_nxt && seq == gen_nxt + 32'd1) begin
        gen_cur = gen_cur + 32'd1;
        gen_nxt = gen_nxt + 32'd1;
      end
    end
  endtask

  // mostly in-window traffic with random payload, some rejects and bad ids
  task automatic queue_random(input int n);
    int k, pick;
    logic [7:0] dev;
    logic [31:0] seq;
    for (k = 0; k < n; k++) begin
      if (gen_count != 0 && $urandom_range(99) < 88) dev = 8'($urandom_range(gen_count - 1));
      else dev = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 34) seq = gen_cur;
      else if (pick < 66) seq = gen_nxt;
      else if (pick < 80) seq = gen_nxt + 32'd1;
      else if (pick < 84) seq = 32'd0;
      else if (pick < 92) seq = $urandom;
      else if (pick < 96) seq = gen_nxt + 32'd2;
      else seq = gen_cur - 32'd1;
      queue_record(dev, seq, $urandom, $urandom, $urandom);
    end
  endtask

  // sender pauses until every word has come back and the block is quiet
  task automatic drain();
    while (records_to_send.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : test_sequence
    int p;
    gen_cur = 32'd0;
    gen_nxt = 32'd0;
    gen_count = SENSOR_COUNT_RESET;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed pass on a four sensor frame
    set_sensor_count(6'd4);
    // next+1 straight out of reset publishes an empty frame
    queue_record(8'd0, 32'd1, 32'h1111_0000, 32'h2222_0000, 32'h0000_0001);
    // current and next both 1, current wins
    queue_record(8'd2, 32'd1, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004);
    // restart with the widest payload
    queue_record(8'd3, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
    // restart again while current is already zero
    queue_record(8'd0, 32'd0, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);
    queue_record(8'd1, 32'd1, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'hffff_ffff);
    // id equal to the count, then the top id on a publishing sequence
    queue_record(8'd4, 32'd0, 32'h1234_5678, 32'h9abc_def0, 32'h0000_0000);
    queue_record(8'd255, 32'd2, 32'hdead_beef, 32'hcafe_f00d, 32'h8000_0001);
    // out of window, both small and all ones
    queue_record(8'd2, 32'd5, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_record(8'd1, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    // publish a frame with holes, then keep rolling the window
    queue_record(8'd2, 32'd2, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_00ff);
    queue_record(8'd0, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_record(8'd3, 32'd3, 32'h0000_0010, 32'h0000_0020, 32'hffff_fff0);
    queue_record(8'd3, 32'd3, 32'h0000_0011, 32'h0000_0021, 32'hffff_fff1);
    queue_record(8'd1, 32'd4, 32'h0000_0030, 32'h0000_0040, 32'h0000_0050);
    queue_record(8'd0, 32'd4, 32'h0000_0060, 32'h0000_0070, 32'h0000_0080);
    queue_record(8'd2, 32'd5, 32'h0000_0090, 32'h0000_00a0, 32'h0000_00b0);
    drain();

    // full frame, no idling at all
    set_sensor_count(6'd32);
    steady = 1'b1;
    queue_random(80);
    drain();
    steady = 1'b0;

    // count above the limit saturates; long output stall fills the block
    set_sensor_count(6'd63);
    hold_requests = hold_requests + 1;
    queue_random(70);
    drain();

    // empty frame flags every record
    set_sensor_count(6'd0);
    queue_random(20);
    drain();

    set_sensor_count(6'd1);
    queue_random(50);
    drain();

    for (p = 0; p < 4; p++) begin
      set_sensor_count(6'($urandom_range(2, 31)));
      queue_random(55);
      drain();
    end

    repeat (80) @(negedge clk);
    $display("covered %0d records over %0d sensor count settings", records_taken,
             counts_used);
    $display("words: %0d accepted, %0d out of window, %0d bad id, %0d published entries",
             kinds_seen[KIND_ACCEPT], kinds_seen[KIND_SEQ_OOW], kinds_seen[KIND_BAD_ID],
             kinds_seen[KIND_ENTRY]);
    if (mismatches == 0) begin
      $display("sequence_window_frame_assembler_core_tb: clean");
    end else begin
      $display("sequence_window_frame_assembler_core_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
    $display("sequence_window_frame_assembler_core_tb: errors");
    $finish;
  end

endmodule
